// ===== rtl/sha256_pkg.sv =====
// Shared constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned STATE_WORDS = 8;
   localparam int unsigned ROUNDS      = 64;

   localparam logic [2:0] VB_FULL     = 3'd4;
   localparam logic [3:0] POS_LEN_HI  = 4'd14;
   localparam logic [3:0] POS_LAST    = 4'd15;
   localparam logic [5:0] ROUND_LAST  = 6'd63;
   localparam logic [3:0] DIGEST_MAX  = 4'd8;
   localparam logic [3:0] DIGEST_RESET = 4'd8;
   localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;

   localparam logic [WORD_W-1:0] IV [STATE_WORDS] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== rtl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: block gathering, padding, round unit and digest output.
//
// Streams a message in as big-endian 32-bit words and returns its SHA-256 digest,
// word 0 first, as 1 to 8 words set by csr_digest_word_count. One shared round
// unit does one of the 64 rounds per cycle; each word is shifted into the block
// window, and every full 16-word block is then compressed (64 rounds plus the
// chaining add). A last word adds padding words and one or two block compressions,
// then the digest words, one per cycle while rsp_ready is high. req_ready is low
// from a block fill until the compression ends, and from a last word until the
// final digest word is taken.
module sha256_stream_hasher
   import sha256_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_message_word,
   input  logic [2:0]        req_valid_bytes,
   input  logic              req_last_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_digest_word,
   output logic              rsp_digest_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_digest_word_count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  chain_ff [STATE_WORDS];
   logic [WORD_W-1:0]  chain_in [STATE_WORDS];
   logic [WORD_W-1:0]  wv_ff [STATE_WORDS];
   logic [WORD_W-1:0]  wv_in [STATE_WORDS];
   logic [WORD_W-1:0]  win_ff [BLOCK_WORDS];
   logic [WORD_W-1:0]  win_in [BLOCK_WORDS];
   logic [3:0]         pos_ff, pos_in;
   logic [63:0]        len_ff, len_in;
   logic [5:0]         round_ff, round_in;
   logic               pad_active_ff, pad_active_in;
   logic               pend80_ff, pend80_in;
   logic               skip_len_ff, skip_len_in;
   logic               final_ff, final_in;
   logic [3:0]         count_ff, count_in;
   logic [2:0]         out_idx_ff, out_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               push_en;
   logic [WORD_W-1:0]  push_val;
   logic [2:0]         vb_sat;
   logic [2:0]         last_idx;
   logic [2:0]         next_idx;
   logic [WORD_W-1:0]  t1;
   logic [WORD_W-1:0]  t2;
   logic [WORD_W-1:0]  sched;

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_digest_last = rsp_last_ff;

   assign vb_sat   = (req_valid_bytes > VB_FULL) ? VB_FULL : req_valid_bytes;
   assign next_idx = 3'(out_idx_ff + 3'd1);

   always_comb begin
      if (count_ff == 4'd0) begin
         last_idx = 3'd0;
      end else if (count_ff > DIGEST_MAX) begin
         last_idx = 3'(DIGEST_MAX - 4'd1);
      end else begin
         last_idx = 3'(count_ff - 4'd1);
      end
   end

   // round unit
   assign t1 = wv_ff[7] + big_sigma1(wv_ff[4])
             + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
             + ROUND_K[round_ff] + win_ff[0];
   assign t2 = big_sigma0(wv_ff[0])
             + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));
   assign sched = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9] + small_sigma1(win_ff[14]);

   always_comb begin
      state_in      = state_ff;
      chain_in      = chain_ff;
      wv_in         = wv_ff;
      win_in        = win_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      round_in      = round_ff;
      pad_active_in = pad_active_ff;
      pend80_in     = pend80_ff;
      skip_len_in   = skip_len_ff;
      final_in      = final_ff;
      count_in      = count_ff;
      out_idx_in    = out_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      push_en       = 1'b0;
      push_val      = '0;

      if (csr_valid) begin
         count_in = csr_digest_word_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               push_en = 1'b1;
               if (!req_last_word) begin
                  len_in   = len_ff + 64'd32;
                  push_val = req_message_word;
               end else begin
                  len_in        = len_ff + {58'd0, vb_sat, 3'b000};
                  pad_active_in = 1'b1;
                  pend80_in     = (vb_sat == VB_FULL);
                  skip_len_in   = (vb_sat != VB_FULL) && (pos_ff == POS_LEN_HI);
                  case (vb_sat)
                     3'd0:    push_val = PAD_WORD;
                     3'd1:    push_val = {req_message_word[31:24], 24'h80_0000};
                     3'd2:    push_val = {req_message_word[31:16], 16'h8000};
                     3'd3:    push_val = {req_message_word[31:8], 8'h80};
                     default: push_val = req_message_word;
                  endcase
               end
               if (pos_ff == POS_LAST) begin
                  state_in = ST_ROUND;
                  wv_in    = chain_ff;
                  round_in = '0;
               end else if (req_last_word) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (pend80_ff) begin
               push_val    = PAD_WORD;
               pend80_in   = 1'b0;
               skip_len_in = (pos_ff == POS_LEN_HI);
            end else if (!skip_len_ff && pos_ff == POS_LEN_HI) begin
               push_val = len_ff[63:32];
            end else if (!skip_len_ff && pos_ff == POS_LAST) begin
               push_val = len_ff[31:0];
               final_in = 1'b1;
            end else begin
               push_val = '0;
               if (pos_ff == POS_LAST) begin
                  skip_len_in = 1'b0;
               end
            end
            if (pos_ff == POS_LAST) begin
               state_in = ST_ROUND;
               wv_in    = chain_ff;
               round_in = '0;
            end
         end
         ST_ROUND: begin
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[BLOCK_WORDS-1] = sched;
            round_in = 6'(round_ff + 6'd1);
            if (round_ff == ROUND_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            for (int i = 0; i < STATE_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + wv_ff[i];
            end
            if (final_ff) begin
               state_in     = ST_OUT;
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[0] + wv_ff[0];
               rsp_last_in  = (last_idx == 3'd0);
               out_idx_in   = '0;
            end else if (pad_active_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (rsp_last_ff) begin
                  state_in      = ST_IDLE;
                  rsp_valid_in  = 1'b0;
                  chain_in      = IV;
                  pos_in        = '0;
                  len_in        = '0;
                  pad_active_in = 1'b0;
                  pend80_in     = 1'b0;
                  skip_len_in   = 1'b0;
                  final_in      = 1'b0;
               end else begin
                  out_idx_in  = next_idx;
                  rsp_word_in = chain_ff[next_idx];
                  rsp_last_in = (next_idx == last_idx);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push_en) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[BLOCK_WORDS-1] = push_val;
         pos_in = 4'(pos_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chain_ff      <= IV;
         pos_ff        <= '0;
         len_ff        <= '0;
         round_ff      <= '0;
         pad_active_ff <= 1'b0;
         pend80_ff     <= 1'b0;
         skip_len_ff   <= 1'b0;
         final_ff      <= 1'b0;
         count_ff      <= DIGEST_RESET;
         out_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chain_ff      <= chain_in;
         wv_ff         <= wv_in;
         win_ff        <= win_in;
         pos_ff        <= pos_in;
         len_ff        <= len_in;
         round_ff      <= round_in;
         pad_active_ff <= pad_active_in;
         pend80_ff     <= pend80_in;
         skip_len_ff   <= skip_len_in;
         final_ff      <= final_in;
         count_ff      <= count_in;
         out_idx_ff    <= out_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while digest words pending");

   a_last_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_word) |=> !req_ready)
      else $error("input ready right after last word");

   a_digest_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_digest_last) |=> (!rsp_valid && req_ready))
      else $error("digest did not end after last word");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == ROUND_LAST) |=> (state_ff == ST_UPDATE))
      else $error("compression did not finish after last round");

endmodule

// ===== tb/sha256_digest_checker.sv =====
// Checker for the SHA-256 stream hasher: predicts digests from accepted words and compares.
module sha256_digest_checker
   import sha256_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [31:0]       req_message_word,
   input  logic [2:0]        req_valid_bytes,
   input  logic              req_last_word,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [31:0]       rsp_digest_word,
   input  logic              rsp_digest_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [3:0]        csr_digest_word_count,
   output int unsigned       mismatch_count,
   output int unsigned       digests_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } digest_entry_type;

   logic [31:0]      chain [STATE_WORDS];
   logic [31:0]      blk [BLOCK_WORDS];
   logic [3:0]       fill_pos;
   logic [63:0]      msg_bits;
   logic [3:0]       digest_count;
   digest_entry_type expected_digests [$];
   int unsigned      error_count = 0;

   function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
      logic [63:0] both;
      both = {x, x} >> n;
      return both[31:0];
   endfunction

   task automatic compress_block();
      logic [31:0] sched [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) sched[t] = blk[t];
      for (int t = 16; t < 64; t++) begin
         s0 = ror(sched[t-15], 7) ^ ror(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = ror(sched[t-2], 17) ^ ror(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_K[t] + sched[t];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
   endtask

   task automatic put_word(input logic [31:0] w);
      blk[fill_pos] = w;
      fill_pos = fill_pos + 4'd1;
      if (fill_pos == 4'd0) compress_block();
   endtask

   task automatic restart_hash();
      for (int i = 0; i < STATE_WORDS; i++) chain[i] = IV[i];
      fill_pos = '0;
      msg_bits = '0;
   endtask

   task automatic absorb_word(input logic [31:0] w, input logic [2:0] vb_in,
                              input logic last);
      int               vb;
      int               n;
      logic [31:0]      mask;
      digest_entry_type ent;
      if (!last) begin
         msg_bits += 64'd32;
         put_word(w);
         return;
      end
      vb = (vb_in > VB_FULL) ? 4 : int'(vb_in);
      msg_bits += 64'(vb * 8);
      if (vb == 4) begin
         put_word(w);
         put_word(PAD_WORD);
      end else begin
         mask = (vb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * vb));
         put_word((w & mask) | (32'h80 << (24 - 8 * vb)));
      end
      if (fill_pos > POS_LEN_HI) begin
         while (fill_pos != 4'd0) put_word(32'h0);
      end
      while (fill_pos < POS_LEN_HI) put_word(32'h0);
      put_word(msg_bits[63:32]);
      put_word(msg_bits[31:0]);
      n = int'(digest_count);
      if (n < 1) n = 1;
      if (n > int'(DIGEST_MAX)) n = int'(DIGEST_MAX);
      for (int k = 0; k < n; k++) begin
         ent.word = chain[k];
         ent.last = (k + 1 == n);
         expected_digests.push_back(ent);
      end
      restart_hash();
   endtask

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      digest_entry_type want;
      if (reset) begin
         restart_hash();
         for (int i = 0; i < BLOCK_WORDS; i++) blk[i] = '0;
         digest_count = DIGEST_RESET;
         expected_digests.delete();
      end else begin
         if (csr_valid && csr_ready) digest_count = csr_digest_word_count;
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               flag_error($sformatf("unexpected digest word %08h last %0d",
                                    rsp_digest_word, rsp_digest_last));
            end else begin
               want = expected_digests.pop_front();
               if (rsp_digest_word !== want.word || rsp_digest_last !== want.last)
                  flag_error($sformatf("digest mismatch: expected %08h last %0d, got %08h last %0d",
                                       want.word, want.last, rsp_digest_word,
                                       rsp_digest_last));
            end
         end
         if (req_valid && req_ready)
            absorb_word(req_message_word, req_valid_bytes, req_last_word);
      end
      digests_pending <= expected_digests.size();
      mismatch_count  <= error_count;
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the SHA-256 stream hasher: stimulus, stalls and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sha256_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_message_word = '0;
   logic [2:0]  req_valid_bytes = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic        rsp_digest_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_digest_word_count = DIGEST_RESET;

   int unsigned mismatch_count;
   int unsigned digests_pending;
   int unsigned cycle_count = 0;
   int unsigned words_sent = 0;
   bit          steady = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sha256_stream_hasher u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_message_word      (req_message_word),
      .req_valid_bytes       (req_valid_bytes),
      .req_last_word         (req_last_word),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_digest_word       (rsp_digest_word),
      .rsp_digest_last       (rsp_digest_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_digest_word_count (csr_digest_word_count)
   );

   sha256_digest_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_message_word      (req_message_word),
      .req_valid_bytes       (req_valid_bytes),
      .req_last_word         (req_last_word),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_digest_word       (rsp_digest_word),
      .rsp_digest_last       (rsp_digest_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_digest_word_count (csr_digest_word_count),
      .mismatch_count        (mismatch_count),
      .digests_pending       (digests_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_word(input logic [31:0] w, input logic [2:0] vb, input logic last);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_message_word <= w;
      req_valid_bytes  <= vb;
      req_last_word    <= last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic drain_hashes();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (digests_pending == 0);
   endtask

   task automatic set_digest_count(input logic [3:0] count);
      drain_hashes();
      // let any trailing compression finish
      repeat (100) @(negedge clock);
      csr_valid             <= 1'b1;
      csr_digest_word_count <= count;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_message();
      int body_len;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) body_len = $urandom_range(0, 17);
      else if (pick < 8) body_len = $urandom_range(12, 15);
      else body_len = $urandom_range(18, 40);
      for (int i = 0; i < body_len; i++)
         send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
   endtask

   initial begin
      logic [3:0] phase_counts [8];
      int         phase_start;
      phase_counts = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd9, 4'd8, 4'd2, 4'd7};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(32'h0000_0000, 3'd0, 1'b1);
      send_word(32'h6162_6300, 3'd3, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd6, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
      send_word(32'h0000_0000, 3'd4, 1'b1);
      // pad lands at word 14, forcing an extra block
      for (int i = 0; i < 13; i++) send_word($urandom, 3'(i), 1'b0);
      send_word($urandom, 3'd4, 1'b1);

      for (int p = 0; p < 8; p++) begin
         set_digest_count(phase_counts[p]);
         phase_start = words_sent;
         while (words_sent - phase_start < 28) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) drain_hashes();
            send_random_message();
         end
      end

      drain_hashes();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && digests_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int stall;
      forever begin
         @(negedge clock);
         stall = steady ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

endmodule
